@@ rtl/core/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle property, sampled on i_clk, off while i_rst_n is low.
`define PUF_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("puf check failed");

// Property whose consequent is checked in the cycle after its antecedent.
`define PUF_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("puf check failed");

`endif

@@ rtl/core/puf_pkg.sv @@
package puf_pkg;

    localparam int NODES  = 1024;
    localparam int NODE_W = $clog2(NODES);

    localparam logic [1:0] REQ_QUERY    = 2'd0;
    localparam logic [1:0] REQ_LINK     = 2'd1;
    localparam logic [1:0] REQ_ROLLBACK = 2'd2;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic [NODE_W-1:0] keep_depth;
    } t_req;

    typedef struct packed {
        logic              same_set;
        logic              rel_parity;
        logic              conflict;
        logic              merged;
        logic [NODE_W-1:0] depth_now;
        logic              status;
    } t_rsp;

    // One entry of the link table: parity to the parent and the parent id.
    typedef struct packed {
        logic              parity;
        logic [NODE_W-1:0] parent;
    } t_link;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_WALK_A,
        S_WALK_B,
        S_SIZE,
        S_MERGE,
        S_POP_CHK,
        S_POP_RD,
        S_POP_TOP,
        S_POP_SIZE,
        S_FIN
    } t_state;

    // Source of the link table read address.
    typedef enum logic [1:0] {
        PRD_A,
        PRD_B,
        PRD_NEXT,
        PRD_UNDO
    } t_prd_sel;

    typedef struct packed {
        logic     clr_wr;
        logic     accept;
        t_prd_sel prd_sel;
        logic     walk_init;
        logic     walk_step;
        logic     save_a;
        logic     save_b;
        logic     size_sel_pop;
        logic     merge_wr;
        logic     pop_latch_child;
        logic     pop_clear_link;
        logic     pop_size_wr;
        logic     set_status;
        logic     load_out;
    } t_cmd;

    typedef struct packed {
        logic       clr_done;
        logic [1:0] req_type;
        logic       node_zero;
        logic       root_hit;
        logic       same_root;
        logic       depth_gt_keep;
        logic       out_free;
    } t_stat;

endpackage

@@ rtl/core/puf_ctrl.sv @@
module puf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  puf_pkg::t_stat i_stat,
    output puf_pkg::t_cmd  o_cmd
);

    puf_pkg::t_state r_state;
    puf_pkg::t_state n_state;
    logic            is_pair;

    assign is_pair = (i_stat.req_type == puf_pkg::REQ_QUERY)
                  || (i_stat.req_type == puf_pkg::REQ_LINK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= puf_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            puf_pkg::S_CLEAR: begin
                if (i_stat.clr_done) n_state = puf_pkg::S_IDLE;
            end
            puf_pkg::S_IDLE: begin
                if (i_valid) n_state = puf_pkg::S_DISPATCH;
            end
            puf_pkg::S_DISPATCH: begin
                unique case (i_stat.req_type) inside
                    puf_pkg::REQ_QUERY, puf_pkg::REQ_LINK: begin
                        n_state = i_stat.node_zero ? puf_pkg::S_FIN : puf_pkg::S_WALK_A;
                    end
                    puf_pkg::REQ_ROLLBACK: n_state = puf_pkg::S_POP_CHK;
                    default:               n_state = puf_pkg::S_FIN;
                endcase
            end
            puf_pkg::S_WALK_A: begin
                if (i_stat.root_hit) n_state = puf_pkg::S_WALK_B;
            end
            puf_pkg::S_WALK_B: begin
                if (i_stat.root_hit) begin
                    if (i_stat.req_type == puf_pkg::REQ_LINK && !i_stat.same_root) begin
                        n_state = puf_pkg::S_SIZE;
                    end else begin
                        n_state = puf_pkg::S_FIN;
                    end
                end
            end
            puf_pkg::S_SIZE:     n_state = puf_pkg::S_MERGE;
            puf_pkg::S_MERGE:    n_state = puf_pkg::S_FIN;
            puf_pkg::S_POP_CHK: begin
                n_state = i_stat.depth_gt_keep ? puf_pkg::S_POP_RD : puf_pkg::S_FIN;
            end
            puf_pkg::S_POP_RD:   n_state = puf_pkg::S_POP_TOP;
            puf_pkg::S_POP_TOP:  n_state = puf_pkg::S_POP_SIZE;
            puf_pkg::S_POP_SIZE: n_state = puf_pkg::S_POP_CHK;
            puf_pkg::S_FIN: begin
                if (i_stat.out_free) n_state = puf_pkg::S_IDLE;
            end
            default: n_state = puf_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = (r_state != puf_pkg::S_IDLE);
        unique case (r_state)
            puf_pkg::S_CLEAR: o_cmd.clr_wr = 1'b1;
            puf_pkg::S_IDLE:  o_cmd.accept = i_valid;
            puf_pkg::S_DISPATCH: begin
                if (is_pair) begin
                    if (i_stat.node_zero) begin
                        o_cmd.set_status = 1'b1;
                    end else begin
                        o_cmd.walk_init = 1'b1;
                        o_cmd.prd_sel   = puf_pkg::PRD_A;
                    end
                end
            end
            puf_pkg::S_WALK_A: begin
                if (i_stat.root_hit) begin
                    // Node a done: start walking from node b.
                    o_cmd.save_a    = 1'b1;
                    o_cmd.walk_init = 1'b1;
                    o_cmd.prd_sel   = puf_pkg::PRD_B;
                end else begin
                    o_cmd.walk_step = 1'b1;
                    o_cmd.prd_sel   = puf_pkg::PRD_NEXT;
                end
            end
            puf_pkg::S_WALK_B: begin
                if (i_stat.root_hit) begin
                    o_cmd.save_b = 1'b1;
                end else begin
                    o_cmd.walk_step = 1'b1;
                    o_cmd.prd_sel   = puf_pkg::PRD_NEXT;
                end
            end
            puf_pkg::S_SIZE:    o_cmd.size_sel_pop = 1'b0;
            puf_pkg::S_MERGE:   o_cmd.merge_wr = 1'b1;
            puf_pkg::S_POP_CHK: o_cmd.prd_sel = puf_pkg::PRD_UNDO;
            puf_pkg::S_POP_RD: begin
                o_cmd.prd_sel         = puf_pkg::PRD_UNDO;
                o_cmd.pop_latch_child = 1'b1;
            end
            puf_pkg::S_POP_TOP: begin
                o_cmd.size_sel_pop   = 1'b1;
                o_cmd.pop_clear_link = 1'b1;
            end
            puf_pkg::S_POP_SIZE: o_cmd.pop_size_wr = 1'b1;
            puf_pkg::S_FIN:      o_cmd.load_out = i_stat.out_free;
            default:             o_cmd = '0;
        endcase
    end

endmodule

@@ rtl/core/puf_dpath.sv @@
module puf_dpath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  puf_pkg::t_req  i_req,
    input  logic           i_stall,
    input  puf_pkg::t_cmd  i_cmd,
    output puf_pkg::t_stat o_stat,
    output logic           o_valid,
    output puf_pkg::t_rsp  o_rsp
);

    localparam int W = puf_pkg::NODE_W;

    puf_pkg::t_link link_mem [puf_pkg::NODES];
    logic [W-1:0]   size_mem [puf_pkg::NODES];
    logic [W-1:0]   undo_mem [puf_pkg::NODES];

    puf_pkg::t_req  r_req;
    puf_pkg::t_rsp  r_out;
    logic           r_out_valid;
    puf_pkg::t_link r_link_rd;
    logic [W-1:0]   r_size0_rd;
    logic [W-1:0]   r_size1_rd;
    logic [W-1:0]   r_undo_rd;
    logic [W-1:0]   r_cur;
    logic           r_acc;
    logic [W-1:0]   r_ra;
    logic           r_pa;
    logic [W-1:0]   r_rb;
    logic [W-1:0]   r_child;
    logic [W-1:0]   r_top;
    logic [W-1:0]   r_depth;
    logic [W-1:0]   r_clr;
    logic           r_same;
    logic           r_rel;
    logic           r_merged;
    logic           r_status;

    logic [W-1:0]   link_raddr;
    logic [W-1:0]   size_raddr0;
    logic [W-1:0]   size_raddr1;
    logic [W-1:0]   depth_m1;
    logic           a_bigger;
    logic [W-1:0]   small_root;
    logic [W-1:0]   big_root;
    logic           link_we;
    logic [W-1:0]   link_waddr;
    puf_pkg::t_link link_wdata;
    logic           size_we;
    logic [W-1:0]   size_waddr;
    logic [W-1:0]   size_wdata;

    always_comb begin
        unique case (i_cmd.prd_sel)
            puf_pkg::PRD_A:    link_raddr = r_req.node_a;
            puf_pkg::PRD_B:    link_raddr = r_req.node_b;
            puf_pkg::PRD_NEXT: link_raddr = r_link_rd.parent;
            puf_pkg::PRD_UNDO: link_raddr = r_undo_rd;
            default:           link_raddr = r_req.node_a;
        endcase
    end

    assign size_raddr0 = i_cmd.size_sel_pop ? r_child : r_ra;
    assign size_raddr1 = i_cmd.size_sel_pop ? r_link_rd.parent : r_rb;
    assign depth_m1    = r_depth - W'(1);

    // Equal sizes: the root of node a goes under the root of node b.
    assign a_bigger   = (r_size0_rd > r_size1_rd);
    assign small_root = a_bigger ? r_rb : r_ra;
    assign big_root   = a_bigger ? r_ra : r_rb;

    always_comb begin
        link_we    = 1'b0;
        link_waddr = r_clr;
        link_wdata = '0;
        if (i_cmd.clr_wr) begin
            link_we = 1'b1;
        end else if (i_cmd.merge_wr) begin
            link_we           = 1'b1;
            link_waddr        = small_root;
            link_wdata.parity = ~r_rel;
            link_wdata.parent = big_root;
        end else if (i_cmd.pop_clear_link) begin
            link_we    = 1'b1;
            link_waddr = r_child;
        end
    end

    always_comb begin
        size_we    = 1'b0;
        size_waddr = r_clr;
        size_wdata = W'(1);
        if (i_cmd.clr_wr) begin
            size_we = 1'b1;
        end else if (i_cmd.merge_wr) begin
            size_we    = 1'b1;
            size_waddr = big_root;
            size_wdata = r_size0_rd + r_size1_rd;
        end else if (i_cmd.pop_size_wr) begin
            size_we    = 1'b1;
            size_waddr = r_top;
            size_wdata = r_size1_rd - r_size0_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (link_we) link_mem[link_waddr] <= link_wdata;
        r_link_rd <= link_mem[link_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (size_we) size_mem[size_waddr] <= size_wdata;
        r_size0_rd <= size_mem[size_raddr0];
        r_size1_rd <= size_mem[size_raddr1];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.merge_wr) undo_mem[r_depth] <= small_root;
        r_undo_rd <= undo_mem[depth_m1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) r_clr <= r_clr + W'(1);
            if (i_cmd.merge_wr) begin
                r_depth <= r_depth + W'(1);
            end else if (i_cmd.pop_size_wr) begin
                r_depth <= depth_m1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req    <= i_req;
            r_same   <= 1'b0;
            r_rel    <= 1'b0;
            r_merged <= 1'b0;
            r_status <= 1'b0;
        end
        if (i_cmd.walk_init || i_cmd.walk_step) r_cur <= link_raddr;
        if (i_cmd.walk_init) begin
            r_acc <= 1'b0;
        end else if (i_cmd.walk_step) begin
            r_acc <= r_acc ^ r_link_rd.parity;
        end
        if (i_cmd.save_a) begin
            r_ra <= r_cur;
            r_pa <= r_acc;
        end
        if (i_cmd.save_b) begin
            r_rb   <= r_cur;
            r_same <= (r_cur == r_ra);
            r_rel  <= r_pa ^ r_acc;
        end
        if (i_cmd.merge_wr)        r_merged <= 1'b1;
        if (i_cmd.set_status)      r_status <= 1'b1;
        if (i_cmd.pop_latch_child) r_child  <= r_undo_rd;
        if (i_cmd.pop_clear_link)  r_top    <= r_link_rd.parent;
        if (i_cmd.load_out) begin
            r_out.same_set   <= r_same;
            r_out.rel_parity <= r_rel;
            r_out.conflict   <= r_same & ~r_rel;
            r_out.merged     <= r_merged;
            r_out.depth_now  <= r_depth;
            r_out.status     <= r_status;
        end
    end

    assign o_stat.clr_done      = &r_clr;
    assign o_stat.req_type      = r_req.req_type;
    assign o_stat.node_zero     = (r_req.node_a == '0) || (r_req.node_b == '0);
    assign o_stat.root_hit      = (r_link_rd.parent == '0);
    assign o_stat.same_root     = (r_cur == r_ra);
    assign o_stat.depth_gt_keep = (r_depth > r_req.keep_depth);
    assign o_stat.out_free      = !r_out_valid || !i_stall;

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

endmodule

@@ rtl/core/parity_union_find_with_rollback.sv @@
// Disjoint-set table with parity and undo over nodes 1..1023, one request at a
// time. After reset the block sweeps all 1024 entries of its link and size
// tables and stalls the request channel until done. A query or link walks
// node a and then node b to their roots, one table read per hop; the path
// lengths are at most 9 with union by size. A link that merges adds a size
// read and a merge write. A rollback pops merges one by one, each with an
// undo read, a link read, size reads and a size write. The result sits in
// an output register, so the next request is taken as soon as the result
// is loaded, even while it is still stalled downstream.
module parity_union_find_with_rollback (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  puf_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_stall,
    output puf_pkg::t_rsp o_rsp
);

    puf_pkg::t_cmd  cmd;
    puf_pkg::t_stat stat;

    puf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    puf_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_stall (i_stall),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

endmodule

@@ rtl/core/puf_checker.sv @@
`include "assert_macros.svh"

module puf_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_stall,
    input logic          o_valid,
    input logic          i_stall,
    input puf_pkg::t_rsp o_rsp
);

    // A held result keeps its value until taken.
    `PUF_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_rsp))

    // Only one request in flight: an accept closes the door for the next cycle.
    `PUF_ASSERT_NEXT(a_one_in_flight, i_valid && !o_stall, o_stall)

    `PUF_ASSERT(a_conflict, o_valid |-> (o_rsp.conflict == (o_rsp.same_set && !o_rsp.rel_parity)))

    // A rejected request reports no match, parity or merge.
    `PUF_ASSERT(a_reject_quiet, (o_valid && o_rsp.status) |-> !(o_rsp.same_set || o_rsp.rel_parity || o_rsp.merged))

    `PUF_ASSERT(a_merge_distinct, (o_valid && o_rsp.merged) |-> !o_rsp.same_set)

endmodule

bind parity_union_find_with_rollback puf_checker u_puf_checker (.*);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import puf_pkg::*;

    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam int unsigned QUIET_LIMIT = 20000;
    localparam int unsigned DRAIN       = 64;
    localparam int unsigned PHASE_ITEMS = 160;

    // Parity forest predictor plus the queue of responses it still owes.
    class parity_forest_checker;
        logic [NODE_W-1:0] up_link [NODES];
        bit                up_parity [NODES];
        logic [NODE_W-1:0] set_size [NODES];
        logic [NODE_W-1:0] undo_child [NODES];
        int unsigned       undo_depth;
        t_rsp              pending_rsp [$];
        int unsigned       mismatches;

        function new();
            foreach (up_link[i]) begin
                up_link[i]    = '0;
                up_parity[i]  = 1'b0;
                set_size[i]   = 1;
                undo_child[i] = '0;
            end
            undo_depth = 0;
            mismatches = 0;
        endfunction

        function logic [NODE_W-1:0] find_root(input logic [NODE_W-1:0] n, output bit par);
            logic [NODE_W-1:0] cur;
            cur = n;
            par = 1'b0;
            while (up_link[cur] != '0) begin
                par ^= up_parity[cur];
                cur = up_link[cur];
            end
            return cur;
        endfunction

        function void note_request(input t_req r);
            t_rsp              want;
            logic [NODE_W-1:0] ra, rb, lo, hi, child, top;
            bit                pa, pb;
            want = '0;
            if (r.req_type == REQ_QUERY || r.req_type == REQ_LINK) begin
                if (r.node_a == '0 || r.node_b == '0) begin
                    want.status = 1'b1;
                end else begin
                    ra = find_root(r.node_a, pa);
                    rb = find_root(r.node_b, pb);
                    want.same_set   = (ra == rb);
                    want.rel_parity = pa ^ pb;
                    want.conflict   = want.same_set && !want.rel_parity;
                    if (r.req_type == REQ_LINK && !want.same_set) begin
                        // smaller set hangs under the larger; ties absorb node_a's root
                        lo = ra;
                        hi = rb;
                        if (set_size[ra] > set_size[rb]) begin
                            lo = rb;
                            hi = ra;
                        end
                        up_link[lo]   = hi;
                        up_parity[lo] = ~want.rel_parity;
                        set_size[hi]  = set_size[hi] + set_size[lo];
                        undo_child[undo_depth] = lo;
                        undo_depth++;
                        want.merged = 1'b1;
                    end
                end
            end else if (r.req_type == REQ_ROLLBACK) begin
                while (undo_depth > r.keep_depth) begin
                    undo_depth--;
                    child = undo_child[undo_depth];
                    top   = up_link[child];
                    up_link[child]   = '0;
                    up_parity[child] = 1'b0;
                    set_size[top]    = set_size[top] - set_size[child];
                end
            end
            want.depth_now = undo_depth[NODE_W-1:0];
            pending_rsp.insert(pending_rsp.size(), want);
        endfunction

        function void check_field(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_response(input t_rsp got);
            t_rsp want;
            if (pending_rsp.size() == 0) begin
                mismatches++;
                $display("%0t: response mismatch, expected none, actual %p", $time, got);
                return;
            end
            want = pending_rsp.pop_front();
            check_field("same_set", 32'(want.same_set), 32'(got.same_set));
            check_field("rel_parity", 32'(want.rel_parity), 32'(got.rel_parity));
            check_field("conflict", 32'(want.conflict), 32'(got.conflict));
            check_field("merged", 32'(want.merged), 32'(got.merged));
            check_field("depth_now", 32'(want.depth_now), 32'(got.depth_now));
            check_field("status", 32'(want.status), 32'(got.status));
        endfunction
    endclass

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_req        i_req   = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_rsp        o_rsp;

    int unsigned idle_pct     = 0;
    int unsigned stall_pct    = 0;
    int unsigned quiet_cycles = 0;

    parity_forest_checker forest = new();

    parity_union_find_with_rollback u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // Check before noting: a response never belongs to the request taken on the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            forest.check_response(o_rsp);
        end
        if (i_rst_n && i_valid && !o_stall) begin
            forest.note_request(i_req);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("parity_union_find_with_rollback regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_req make_req(input logic [1:0] kind, input int unsigned a,
                                      input int unsigned b,
                                      input int unsigned keep);
        t_req r;
        r.req_type   = kind;
        r.node_a     = NODE_W'(a);
        r.node_b     = NODE_W'(b);
        r.keep_depth = NODE_W'(keep);
        return r;
    endfunction

    // Hold the request until taken; valid stays high across back-to-back requests.
    task automatic push_request(input t_req r);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            i_req   <= t_req'($urandom);
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic random_traffic(input int unsigned count);
        int unsigned done_items, mark, base, span, pick, keep;
        t_req        r;
        done_items = 0;
        while (done_items < count) begin
            // work inside a narrow node window so trees get deep and cycles show up
            mark = forest.undo_depth;
            span = $urandom_range(4, 64);
            base = $urandom_range(1, 1024 - span);
            repeat ($urandom_range(3, 12)) begin
                pick = $urandom_range(99);
                r = make_req(pick < 55 ? REQ_LINK : REQ_QUERY,
                             base + $urandom_range(0, span - 1),
                             base + $urandom_range(0, span - 1), $urandom);
                if (pick >= 90) begin
                    r.node_a = NODE_W'($urandom_range(1, NODES - 1));
                    r.node_b = NODE_W'($urandom_range(1, NODES - 1));
                end
                push_request(r);
                done_items++;
            end
            if ($urandom_range(99) < 15) begin
                r = t_req'($urandom);
                if ($urandom_range(1)) begin
                    r.req_type = REQ_UNUSED;
                end else begin
                    r.req_type = $urandom_range(1) ? REQ_LINK : REQ_QUERY;
                    if ($urandom_range(1)) r.node_a = '0;
                    else r.node_b = '0;
                end
                push_request(r);
            end
            // close the segment: mostly back to its mark, sometimes anywhere
            pick = $urandom_range(99);
            if (forest.undo_depth > 300) begin
                keep = $urandom_range(0, forest.undo_depth / 2);
            end else if (pick < 60) begin
                keep = mark;
            end else if (pick < 80) begin
                keep = $urandom_range(0, 1023);
            end else begin
                continue;
            end
            push_request(make_req(REQ_ROLLBACK, $urandom, $urandom, keep));
            done_items++;
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_request(make_req(REQ_QUERY, 1, 2, $urandom));
        push_request(make_req(REQ_QUERY, 0, 5, $urandom));
        push_request(make_req(REQ_LINK, 7, 0, $urandom));
        push_request(make_req(REQ_QUERY, 0, 0, $urandom));
        push_request(make_req(REQ_LINK, 1, 2, $urandom));
        push_request(make_req(REQ_LINK, 2, 3, $urandom));
        push_request(make_req(REQ_QUERY, 1, 3, $urandom));
        push_request(make_req(REQ_LINK, 1, 3, $urandom));
        push_request(make_req(REQ_QUERY, 1, 2, $urandom));
        push_request(make_req(REQ_QUERY, 3, 3, $urandom));
        push_request(make_req(REQ_LINK, 1023, 1022, $urandom));
        push_request(make_req(REQ_LINK, 1023, 1, $urandom));
        push_request(make_req(REQ_QUERY, 1023, 3, $urandom));
        push_request(make_req(REQ_UNUSED, $urandom, $urandom, $urandom));
        push_request(make_req(REQ_ROLLBACK, $urandom, $urandom, 1023));
        push_request(make_req(REQ_ROLLBACK, $urandom, $urandom, 2));
        push_request(make_req(REQ_QUERY, 1023, 1, $urandom));
        push_request(make_req(REQ_ROLLBACK, $urandom, $urandom, 0));
        push_request(make_req(REQ_ROLLBACK, $urandom, $urandom, 0));
        push_request(make_req(REQ_QUERY, 1022, 1023, $urandom));
        push_request(make_req(REQ_LINK, 512, 511, $urandom));
        push_request(make_req(REQ_LINK, 341, 682, $urandom));
        push_request(make_req(REQ_QUERY, 682, 511, $urandom));
        push_request(make_req(REQ_ROLLBACK, 0, 1023, 0));

        random_traffic(PHASE_ITEMS);
        idle_pct = 77;
        random_traffic(PHASE_ITEMS);
        idle_pct  = 0;
        stall_pct = 77;
        random_traffic(PHASE_ITEMS);
        idle_pct  = 38;
        stall_pct = 38;
        random_traffic(PHASE_ITEMS);
        i_valid <= 1'b0;

        while (forest.pending_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (forest.mismatches == 0) begin
            $display("parity_union_find_with_rollback regression: pass");
        end else begin
            $display("parity_union_find_with_rollback regression: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/puf_pkg.sv
rtl/core/puf_ctrl.sv
rtl/core/puf_dpath.sv
rtl/core/parity_union_find_with_rollback.sv
rtl/core/puf_checker.sv
tb/sv/testbench.sv
